/* rtl/core/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int ITEM_W    = 16;
    localparam int PRIO_IN_W = 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [ITEM_W-1:0] item_t;
    typedef logic [CMD_W-1:0]         command_t;
    typedef logic [STATUS_W-1:0]      status_t;

    localparam command_t CMD_ENQ  = 2'd0;
    localparam command_t CMD_DEQ  = 2'd1;
    localparam command_t CMD_DUMP = 2'd2;

    localparam status_t ST_ENQUEUED = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_ITEM     = 2'd2;
    localparam status_t ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_ENQ,
        DP_DEQ,
        DP_DUMP_START,
        DP_ROT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    out_load;
        status_t out_status;
        logic    out_use_head;
        logic    out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
    } dp_stat_t;

endpackage

/* rtl/core/spq_intf.sv */
// Request, response and configuration channel interfaces of the priority queue.
interface spq_req_if
    import spq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    command_t             command;
    item_t                item_in;
    logic [PRIO_IN_W-1:0] priority_in;

    modport source (output valid, output command, output item_in, output priority_in,
                    input ready);
    modport sink   (input valid, input command, input item_in, input priority_in,
                    output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    item_t   item_out;
    logic    last;

    modport source (output valid, output status, output item_out, output last,
                    input ready);
    modport sink   (input valid, input status, input item_out, input last,
                    output ready);
endinterface

interface spq_cfg_if
    import spq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/spq_ctrl.sv */
// Controller of the priority queue: request decode, dump sequencing, response valid.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  command_t in_command,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd.op           = DP_NOP;
        cmd.out_load     = 1'b0;
        cmd.out_status   = ST_ENQUEUED;
        cmd.out_use_head = 1'b0;
        cmd.out_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_command)
                        CMD_ENQ:
                        begin
                            cmd.out_load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.op         = DP_ENQ;
                                cmd.out_status = ST_ENQUEUED;
                            end
                        end
                        CMD_DEQ:
                        begin
                            cmd.out_load = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op           = DP_DEQ;
                                cmd.out_status   = ST_ITEM;
                                cmd.out_use_head = 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = DP_DUMP_START;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // The unused command code is taken and dropped.
                            cmd.op = DP_NOP;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // The ring of live cells rotates once per emitted item, so the
                // array is back in order after the final one.
                if (slot_free)
                begin
                    cmd.op           = DP_ROT;
                    cmd.out_load     = 1'b1;
                    cmd.out_status   = ST_ITEM;
                    cmd.out_use_head = 1'b1;
                    cmd.out_last     = stat.dump_last;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/spq_datapath.sv */
// Datapath of the priority queue: sorted cell array, occupancy, capacity, response payload.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  item_t                item_in,
    input  logic [PRIO_IN_W-1:0] priority_in,
    input  logic                 cfg_write,
    input  logic [CAP_W-1:0]     cfg_data,
    output status_t              status,
    output item_t                item_out,
    output logic                 last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic [PRIO_WIDTH-1:0] prio_t;

    item_t            item_reg [DEPTH];
    item_t            item_next [DEPTH];
    prio_t            prio_reg [DEPTH];
    prio_t            prio_next [DEPTH];
    item_t            item_up [DEPTH];
    item_t            item_dn [DEPTH];
    prio_t            prio_up [DEPTH];
    prio_t            prio_dn [DEPTH];
    logic [DEPTH-1:0] in_use;
    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] at_loc;
    logic [DEPTH-1:0] ring_end;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CMP_W-1:0] cap_eff;
    prio_t            new_prio;

    status_t out_status_reg;
    item_t   out_item_reg;
    logic    out_last_reg;

    // Priorities above the stored width are cut off, below it zero extended.
    assign new_prio = PRIO_WIDTH'(priority_in);

    assign cap_eff = (CMP_W'(cap_reg) < CMP_W'(DEPTH)) ? CMP_W'(cap_reg) : CMP_W'(DEPTH);

    assign stat.empty     = (occ_reg == '0);
    assign stat.full      = (CMP_W'(occ_reg) >= cap_eff);
    assign stat.dump_last = ((cnt_reg + CNT_W'(1)) == occ_reg);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            assign in_use[g]   = (CNT_W'(g) < occ_reg);
            assign ring_end[g] = (CNT_W'(g + 1) == occ_reg);
            assign lt[g]       = in_use[g] && (prio_reg[g] < new_prio);
            if (g == DEPTH - 1)
            begin : g_top
                assign item_up[g] = item_reg[g];
                assign prio_up[g] = prio_reg[g];
            end
            else
            begin : g_mid
                assign item_up[g] = item_reg[g + 1];
                assign prio_up[g] = prio_reg[g + 1];
            end
            if (g == 0)
            begin : g_bot
                assign item_dn[g] = item_reg[g];
                assign prio_dn[g] = prio_reg[g];
                assign at_loc[g]  = !lt[g];
            end
            else
            begin : g_rest
                assign item_dn[g] = item_reg[g - 1];
                assign prio_dn[g] = prio_reg[g - 1];
                assign at_loc[g]  = !lt[g] && lt[g - 1];
            end
        end
    endgenerate

    always_comb
    begin
        item_next = item_reg;
        prio_next = prio_reg;
        occ_next  = occ_reg;
        cnt_next  = cnt_reg;
        case (cmd.op)
            DP_ENQ:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (at_loc[i])
                    begin
                        item_next[i] = item_in;
                        prio_next[i] = new_prio;
                    end
                    else if (!lt[i])
                    begin
                        item_next[i] = item_dn[i];
                        prio_next[i] = prio_dn[i];
                    end
                end
                occ_next = occ_reg + CNT_W'(1);
            end
            DP_DEQ:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    item_next[i] = item_up[i];
                    prio_next[i] = prio_up[i];
                end
                occ_next = occ_reg - CNT_W'(1);
            end
            DP_DUMP_START:
            begin
                cnt_next = '0;
            end
            DP_ROT:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (in_use[i])
                    begin
                        item_next[i] = ring_end[i] ? item_reg[0] : item_up[i];
                        prio_next[i] = ring_end[i] ? prio_reg[0] : prio_up[i];
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            item_reg[i] <= item_next[i];
            prio_reg[i] <= prio_next[i];
        end
        cnt_reg <= cnt_next;
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_item_reg   <= cmd.out_use_head ? item_reg[0] : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            cap_reg <= CAP_RESET;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign status   = out_status_reg;
    assign item_out = out_item_reg;
    assign last     = out_last_reg;

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
// Enqueue and dequeue: the response is registered and valid in the cycle after the request is
// accepted; one per cycle while the response is not stalled. Dump of n entries: n responses,
// one per cycle while not stalled, from the dump state; the next request is accepted once the
// rotating cell array is back in order. Full and empty reports are registered like the others;
// a stalled response holds the request side. Reset (rst_n low, asynchronous) empties the queue
// and sets capacity to 16; the entry cells themselves are not cleared.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 8
)
(
    input logic      clk,
    input logic      rst_n,
    spq_req_if.sink  req,
    spq_rsp_if.source rsp,
    spq_cfg_if.sink  cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    spq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_command (req.command),
        .in_ready   (req.ready),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    spq_datapath #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .item_in     (req.item_in),
        .priority_in (req.priority_in),
        .cfg_write   (cfg.valid),
        .cfg_data    (cfg.data),
        .status      (rsp.status),
        .item_out    (rsp.item_out),
        .last        (rsp.last)
    );

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks of the priority queue and their bind to the top level.
module spq_port_checker
    import spq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input command_t req_command,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input status_t  rsp_status,
    input item_t    rsp_item_out,
    input logic     rsp_last
);

    // A stalled response keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_item_out) && $stable(rsp_last))
        else $error("stalled response changed");

    // Reports without an item carry a zero item and close their request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_ITEM) |-> (rsp_item_out == '0) && rsp_last)
        else $error("report response malformed");

    // An accepted enqueue is answered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_ENQ) |=> rsp_valid
            && ((rsp_status == ST_ENQUEUED) || (rsp_status == ST_FULL)))
        else $error("enqueue not answered");

    // An accepted dequeue is answered in the next cycle with a single response.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_DEQ) |=> rsp_valid && rsp_last
            && ((rsp_status == ST_ITEM) || (rsp_status == ST_EMPTY)))
        else $error("dequeue not answered");

endmodule

bind sorted_priority_queue_top spq_port_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_command  (req.command),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_item_out (rsp.item_out),
    .rsp_last     (rsp.last)
);

/* sim/spq_checker.sv */
`timescale 1ns / 100ps
// Response checker for the sorted priority queue: tracks the queue contents and compares responses.
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    spq_cfg_if   cfg,
    output int   fail_count,
    output int   awaited
);

    typedef struct {
        status_t status;
        item_t   item;
        logic    last;
    } queue_rsp_t;

    item_t                slot_item [DEPTH];
    logic [PRIO_IN_W-1:0] slot_prio [DEPTH];
    int                   occupancy;
    logic [CAP_W-1:0]     capacity;
    queue_rsp_t           due_rsp [$];
    int                   mismatches = 0;
    int                   due_count = 0;

    assign fail_count = mismatches;
    assign awaited    = due_count;

    // Applies one request to the shadow queue and queues the responses it must produce.
    task automatic predict_request(input command_t op, input item_t item,
                                   input logic [PRIO_IN_W-1:0] prio);
        int limit;
        int pos;
        int i;
        limit = (capacity < DEPTH) ? int'(capacity) : DEPTH;
        case (op)
            CMD_ENQ:
            begin
                if (occupancy >= limit)
                begin
                    due_rsp.push_back('{ST_FULL, '0, 1'b1});
                end
                else
                begin
                    // New entry goes ahead of older entries of the same priority.
                    pos = 0;
                    while (pos < occupancy && slot_prio[pos] < prio)
                        pos++;
                    for (i = occupancy; i > pos; i--)
                    begin
                        slot_item[i] = slot_item[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_item[pos] = item;
                    slot_prio[pos] = prio;
                    occupancy++;
                    due_rsp.push_back('{ST_ENQUEUED, '0, 1'b1});
                end
            end
            CMD_DEQ:
            begin
                if (occupancy == 0)
                begin
                    due_rsp.push_back('{ST_EMPTY, '0, 1'b1});
                end
                else
                begin
                    due_rsp.push_back('{ST_ITEM, slot_item[0], 1'b1});
                    for (i = 1; i < occupancy; i++)
                    begin
                        slot_item[i-1] = slot_item[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    occupancy--;
                end
            end
            CMD_DUMP:
            begin
                if (occupancy == 0)
                    due_rsp.push_back('{ST_EMPTY, '0, 1'b1});
                else
                    for (i = 0; i < occupancy; i++)
                        due_rsp.push_back('{ST_ITEM, slot_item[i], i == occupancy - 1});
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_response();
        queue_rsp_t exp_rsp;
        if (due_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response: status %0d item %0d last %0b",
                         rsp.status, rsp.item_out, rsp.last);
        end
        else
        begin
            exp_rsp = due_rsp.pop_front();
            if (rsp.status !== exp_rsp.status || rsp.item_out !== exp_rsp.item ||
                rsp.last !== exp_rsp.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected status %0d item %0d last %0b, got status %0d item %0d last %0b",
                             exp_rsp.status, exp_rsp.item, exp_rsp.last,
                             rsp.status, rsp.item_out, rsp.last);
            end
        end
    endtask

    // Responses are checked before the request of the same edge is applied, since a
    // response always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy = 0;
            capacity  = CAP_RESET;
            due_rsp.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_response();
            if (cfg.valid && cfg.ready)
                capacity = cfg.data;
            if (req.valid && req.ready)
                predict_request(req.command, req.item_in, req.priority_in);
        end
        due_count = due_rsp.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the priority queue testbench: clock, reset, request stimulus and the verdict.
module tb_top;
    import spq_pkg::*;

    localparam command_t    CMD_UNUSED    = 2'd3;
    localparam int          PHASES        = 10;
    localparam int          PHASE_ITEMS   = 37;
    localparam logic [12:0] READY_PATTERN = 13'b1101101110010;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_t;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          awaited;
    int          burst_left;
    logic [31:0] ready_tick = '0;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();
    spq_cfg_if cfg_if ();

    sorted_priority_queue_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    spq_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Receiver: a fixed stall pattern, with a stall-free window while bits 8:7 of the tick count are set.
    always @(negedge clk)
    begin
        ready_tick++;
        rsp_if.ready <= (ready_tick[8:7] == 2'b11) ? 1'b1 : READY_PATTERN[4'(ready_tick % 13)];
    end

    // Sends one request; requests come in bursts separated by random gaps, which may be empty.
    task automatic send_request(input command_t op, input item_t item,
                                input logic [PRIO_IN_W-1:0] prio);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.command     <= op;
        req_if.item_in     <= item;
        req_if.priority_in <= prio;
        burst_left--;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic pause_until_drained(input int settle);
        @(negedge clk);
        req_if.valid <= 1'b0;
        burst_left = 0;
        wait (awaited == 0);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int       p;
        int       sent;
        int       pick;
        int       enq_pct;
        int       deq_pct;
        traffic_t mode;
        command_t op;
        logic [PRIO_IN_W-1:0] prio;
        int       cap_plan [5];

        cap_plan           = '{31, 0, 1, 16, 3};
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.command     = CMD_ENQ;
        req_if.item_in     = '0;
        req_if.priority_in = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        burst_left         = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, ignored command, extremes and equal priorities.
        send_request(CMD_DEQ, 16'h0000, 8'h00);
        send_request(CMD_DUMP, 16'h0000, 8'h00);
        send_request(CMD_UNUSED, 16'h8000, 8'hFF);
        send_request(CMD_ENQ, 16'h7FFF, 8'hFF);
        send_request(CMD_ENQ, 16'h8000, 8'h00);
        send_request(CMD_ENQ, 16'h5555, 8'h00);
        send_request(CMD_ENQ, 16'hAAAA, 8'h80);
        send_request(CMD_ENQ, 16'h0001, 8'hFF);
        send_request(CMD_DUMP, 16'hFFFF, 8'hFF);
        send_request(CMD_UNUSED, 16'h1234, 8'h01);
        send_request(CMD_ENQ, 16'hFFFF, 8'h01);
        repeat (7) send_request(CMD_DEQ, 16'h0000, 8'h00);
        send_request(CMD_DUMP, 16'h0000, 8'h00);

        for (p = 0; p < PHASES; p++)
        begin
            // A quiet stretch with nothing in flight before each capacity change.
            pause_until_drained(24);
            @(negedge clk);
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= (p < 5) ? CAP_W'(cap_plan[p]) : CAP_W'($urandom_range(0, 31));
            do @(posedge clk); while (!cfg_if.ready);
            @(negedge clk);
            cfg_if.valid <= 1'b0;

            case (p)
                0, 3:    mode = MODE_FILL;
                1:       mode = MODE_DRAIN;
                2, 4:    mode = MODE_MIXED;
                default: mode = traffic_t'($urandom_range(0, 2));
            endcase
            enq_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 25 : 45;
            deq_pct = (mode == MODE_FILL) ? 15 : (mode == MODE_DRAIN) ? 55 : 35;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < enq_pct)
                    op = CMD_ENQ;
                else if (pick < enq_pct + deq_pct)
                    op = CMD_DEQ;
                else if (pick < enq_pct + deq_pct + 15)
                    op = CMD_DUMP;
                else
                    op = CMD_UNUSED;

                // Half of the priorities are small, 0 to 3, so that ties are common.
                pick = $urandom_range(0, 7);
                if (pick < 4)
                    prio = PRIO_IN_W'($urandom_range(0, 3));
                else if (pick == 4)
                    prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                else
                    prio = PRIO_IN_W'($urandom_range(0, 255));

                send_request(op, item_t'($urandom_range(0, 65535)), prio);
                if (op != CMD_UNUSED)
                    sent++;
                if (sent == 20 && op != CMD_UNUSED && (p == 2 || $urandom_range(0, 1) == 1))
                    pause_until_drained(0);
            end
        end

        pause_until_drained(40);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
